>>> hdl/lap3d_pkg.sv
`default_nettype none

package lap3d_pkg;

	localparam int EDGE_MAX    = 16;
	localparam int SAMPLE_BITS = 32;

	// ring of two planes plus one sample
	localparam int WIN_SIZE = 2 * EDGE_MAX * EDGE_MAX + 1;
	localparam int AW       = $clog2(WIN_SIZE);
	localparam int EW       = $clog2(EDGE_MAX + 1);
	localparam int CW       = (EDGE_MAX > 2) ? $clog2(EDGE_MAX) : 1;
	localparam int PW       = $clog2(EDGE_MAX * EDGE_MAX + 1);
	localparam int SUM_W    = SAMPLE_BITS + 4;

	// port field widths
	localparam int SAMPLE_W  = 32;
	localparam int RATE_W    = 52;
	localparam int IDX_W     = 12;
	localparam int EDGE_IN_W = 5;
	localparam int SCALE_W   = 24;

	// APB port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int CQ_DEPTH = 2;

	localparam int EDGE_RESET  = 16;
	localparam int SCALE_RESET = 640000;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	localparam logic REG_EDGE  = 1'b0;
	localparam logic REG_SCALE = 1'b1;

	typedef struct packed {
		logic zm;
		logic ym;
		logic xm;
		logic xp;
		logic yp;
		logic zp;
	} nbr_t;

	typedef struct packed {
		logic [AW-1:0]    addr;
		logic [IDX_W-1:0] idx;
		nbr_t             nbr;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic                   we;
		logic [AW-1:0]          addr;
		logic [SAMPLE_BITS-1:0] data;
	} wr_t;

	typedef struct packed {
		logic empty;
		logic full;
	} cq_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_MUL,
		BK_OUT
	} bk_state_t;

endpackage

`default_nettype wire

>>> hdl/lap3d_ram.sv
`default_nettype none

module lap3d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 513
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> hdl/lap3d_front.sv
`default_nettype none

module lap3d_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire logic                               opcode,
	input  wire logic signed [lap3d_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [lap3d_pkg::CW-1:0]           em1,
	input  wire logic                               restart,
	input  wire lap3d_pkg::cq_stat_t                cq_stat,
	output logic                                    full,
	output lap3d_pkg::wr_t                          wr,
	output logic                                    cq_push,
	output lap3d_pkg::cmd_t                         cq_cmd
);
	import lap3d_pkg::*;

	logic [CW-1:0]    ix_q, iy_q, iz_q;
	logic [CW-1:0]    ox_q, oy_q, oz_q;
	logic [AW-1:0]    in_addr_q, out_addr_q;
	logic [IDX_W-1:0] out_pos_q;
	logic             in_done_q;

	logic [CW-1:0]    ix_d, iy_d, iz_d;
	logic [CW-1:0]    ox_d, oy_d, oz_d;
	logic [AW-1:0]    in_addr_d, out_addr_d;
	logic [IDX_W-1:0] out_pos_d;
	logic             in_done_d;

	logic accept, is_sample, do_write, emit, o_last, i_last;

	// while the volume fills, a sample may overwrite the oldest slot that a
	// queued point still needs, so hold input until the back end took it
	assign full = cq_stat.full || (!in_done_q && !cq_stat.empty);

	always_comb begin
		accept    = push && !full;
		is_sample = (opcode == OP_SAMPLE);
		do_write  = accept && is_sample && !in_done_q;
		emit      = accept && ((do_write && (iz_q != '0)) ||
			(!is_sample && in_done_q));
		o_last    = (ox_q == em1) && (oy_q == em1) && (oz_q == em1);
		i_last    = (ix_q == em1) && (iy_q == em1) && (iz_q == em1);

		wr.we   = do_write;
		wr.addr = in_addr_q;
		wr.data = sample[SAMPLE_BITS-1:0];

		cq_push         = emit;
		cq_cmd.addr     = out_addr_q;
		cq_cmd.idx      = out_pos_q;
		cq_cmd.nbr.zm   = (oz_q != '0);
		cq_cmd.nbr.ym   = (oy_q != '0);
		cq_cmd.nbr.xm   = (ox_q != '0);
		cq_cmd.nbr.xp   = (ox_q != em1);
		cq_cmd.nbr.yp   = (oy_q != em1);
		cq_cmd.nbr.zp   = (oz_q != em1);
		cq_cmd.last     = o_last;

		ix_d       = ix_q;
		iy_d       = iy_q;
		iz_d       = iz_q;
		in_addr_d  = in_addr_q;
		in_done_d  = in_done_q;
		ox_d       = ox_q;
		oy_d       = oy_q;
		oz_d       = oz_q;
		out_addr_d = out_addr_q;
		out_pos_d  = out_pos_q;

		if (do_write) begin
			in_addr_d = (in_addr_q == AW'(WIN_SIZE - 1)) ? '0 : in_addr_q + 1'b1;
			in_done_d = i_last;
			if (ix_q != em1) begin
				ix_d = ix_q + 1'b1;
			end else begin
				ix_d = '0;
				if (iy_q != em1) begin
					iy_d = iy_q + 1'b1;
				end else begin
					iy_d = '0;
					iz_d = (iz_q != em1) ? iz_q + 1'b1 : '0;
				end
			end
		end

		if (emit) begin
			out_addr_d = (out_addr_q == AW'(WIN_SIZE - 1)) ? '0 : out_addr_q + 1'b1;
			out_pos_d  = out_pos_q + 1'b1;
			if (ox_q != em1) begin
				ox_d = ox_q + 1'b1;
			end else begin
				ox_d = '0;
				if (oy_q != em1) begin
					oy_d = oy_q + 1'b1;
				end else begin
					oy_d = '0;
					oz_d = (oz_q != em1) ? oz_q + 1'b1 : '0;
				end
			end
		end

		// end of volume or new edge length: start over
		if (restart || (emit && o_last)) begin
			ix_d       = '0;
			iy_d       = '0;
			iz_d       = '0;
			in_addr_d  = '0;
			in_done_d  = 1'b0;
			ox_d       = '0;
			oy_d       = '0;
			oz_d       = '0;
			out_addr_d = '0;
			out_pos_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix_q       <= '0;
			iy_q       <= '0;
			iz_q       <= '0;
			in_addr_q  <= '0;
			in_done_q  <= 1'b0;
			ox_q       <= '0;
			oy_q       <= '0;
			oz_q       <= '0;
			out_addr_q <= '0;
			out_pos_q  <= '0;
		end else begin
			ix_q       <= ix_d;
			iy_q       <= iy_d;
			iz_q       <= iz_d;
			in_addr_q  <= in_addr_d;
			in_done_q  <= in_done_d;
			ox_q       <= ox_d;
			oy_q       <= oy_d;
			oz_q       <= oz_d;
			out_addr_q <= out_addr_d;
			out_pos_q  <= out_pos_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/lap3d_cmdq.sv
`default_nettype none

module lap3d_cmdq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire lap3d_pkg::cmd_t     push_cmd,
	input  wire logic                pop,
	output lap3d_pkg::cq_stat_t      stat,
	output lap3d_pkg::cmd_t          head
);
	import lap3d_pkg::*;

	localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CQ_DEPTH + 1);

	cmd_t             ent_q [CQ_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_W'(CQ_DEPTH));
	assign head       = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(CQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(CQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> hdl/lap3d_back.sv
`default_nettype none

module lap3d_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [lap3d_pkg::EW-1:0]              e,
	input  wire logic [lap3d_pkg::PW-1:0]              plane,
	input  wire logic [lap3d_pkg::SCALE_W-1:0]         scale,
	input  wire lap3d_pkg::cq_stat_t                   cq_stat,
	input  wire lap3d_pkg::cmd_t                       cq_head,
	output logic                                       cq_pop,
	output logic [lap3d_pkg::AW-1:0]                   raddr,
	input  wire logic [lap3d_pkg::SAMPLE_BITS-1:0]     rdata,
	input  wire logic                                  pop,
	output logic                                       res_valid,
	output logic signed [lap3d_pkg::RATE_W-1:0]        rate_value,
	output logic [lap3d_pkg::IDX_W-1:0]                point_index,
	output logic                                       last_of_volume
);
	import lap3d_pkg::*;

	// read order: the slot at risk of overwrite goes first
	localparam logic [2:0] SLOT_ZM = 3'd0;
	localparam logic [2:0] SLOT_C  = 3'd1;
	localparam logic [2:0] SLOT_YM = 3'd2;
	localparam logic [2:0] SLOT_XM = 3'd3;
	localparam logic [2:0] SLOT_XP = 3'd4;
	localparam logic [2:0] SLOT_YP = 3'd5;
	localparam logic [2:0] SLOT_ZP = 3'd6;
	localparam logic [2:0] LAST_STEP = 3'd7;

	localparam int PROD_W = SUM_W + SCALE_W + 1;
	localparam int WIDE_W = (PROD_W > RATE_W + 1) ? PROD_W : RATE_W + 1;
	localparam logic signed [WIDE_W-1:0] RATE_HI =
		{{(WIDE_W - RATE_W + 1){1'b0}}, {(RATE_W - 1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] RATE_LO =
		{{(WIDE_W - RATE_W + 1){1'b1}}, {(RATE_W - 1){1'b0}}};

	function automatic logic [AW-1:0] ring_off(input logic [AW-1:0] base,
		input logic sub, input logic [PW-1:0] off);
		logic [AW:0] t;
		if (sub) begin
			t = {1'b0, base} + (AW + 1)'(WIN_SIZE) - (AW + 1)'(off);
		end else begin
			t = {1'b0, base} + (AW + 1)'(off);
		end
		if (t >= (AW + 1)'(WIN_SIZE)) begin
			t = t - (AW + 1)'(WIN_SIZE);
		end
		ring_off = t[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] base,
		input logic [2:0] slot, input logic [EW-1:0] ev, input logic [PW-1:0] pl);
		logic [PW-1:0] ew;
		ew = PW'(ev);
		unique case (slot)
			SLOT_ZM: slot_addr = ring_off(base, 1'b1, pl);
			SLOT_YM: slot_addr = ring_off(base, 1'b1, ew);
			SLOT_XM: slot_addr = ring_off(base, 1'b1, PW'(1));
			SLOT_XP: slot_addr = ring_off(base, 1'b0, PW'(1));
			SLOT_YP: slot_addr = ring_off(base, 1'b0, ew);
			SLOT_ZP: slot_addr = ring_off(base, 1'b0, pl);
			default: slot_addr = base;
		endcase
	endfunction

	function automatic logic slot_on(input nbr_t n, input logic [2:0] slot);
		unique case (slot)
			SLOT_ZM: slot_on = n.zm;
			SLOT_YM: slot_on = n.ym;
			SLOT_XM: slot_on = n.xm;
			SLOT_XP: slot_on = n.xp;
			SLOT_YP: slot_on = n.yp;
			SLOT_ZP: slot_on = n.zp;
			default: slot_on = 1'b0;
		endcase
	endfunction

	bk_state_t state_q, state_d;
	logic [2:0] step_q;
	cmd_t       cmd_q;
	logic signed [SUM_W-1:0]  acc_q, cen_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  vext;
	logic signed [WIDE_W-1:0] sh;
	logic [2:0]               dslot;
	logic                     load_res;
	logic signed [RATE_W-1:0] rate_sat;

	assign vext  = {{(SUM_W - SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
	assign dslot = step_q - 1'b1;

	always_comb begin
		state_d  = state_q;
		cq_pop   = 1'b0;
		load_res = 1'b0;
		raddr    = slot_addr(cmd_q.addr, step_q, e, plane);
		unique case (state_q)
			BK_IDLE: begin
				raddr = slot_addr(cq_head.addr, SLOT_ZM, e, plane);
				if (!cq_stat.empty) begin
					cq_pop  = 1'b1;
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (step_q == LAST_STEP) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!res_valid || pop) begin
					load_res = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		sh = prod_q;
		sh = sh >>> 8;
		if (sh > RATE_HI) begin
			rate_sat = RATE_HI[RATE_W-1:0];
		end else if (sh < RATE_LO) begin
			rate_sat = RATE_LO[RATE_W-1:0];
		end else begin
			rate_sat = sh[RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			step_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cq_pop) begin
				step_q <= 3'd1;
			end else if (state_q == BK_READ) begin
				step_q <= step_q + 1'b1;
			end
			if (load_res) begin
				res_valid <= 1'b1;
			end else if (pop) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cq_pop) begin
			cmd_q <= cq_head;
		end
		if (state_q == BK_READ) begin
			unique case (dslot)
				SLOT_ZM: acc_q <= cmd_q.nbr.zm ? vext : '0;
				SLOT_C: begin
					cen_q <= vext;
					acc_q <= acc_q - (cmd_q.nbr.zm ? vext : SUM_W'(0));
				end
				default: acc_q <= acc_q + (slot_on(cmd_q.nbr, dslot) ? vext - cen_q : SUM_W'(0));
			endcase
		end
		if (state_q == BK_MUL) begin
			prod_q <= acc_q * $signed({1'b0, scale});
		end
		if (load_res) begin
			rate_value     <= rate_sat;
			point_index    <= cmd_q.idx;
			last_of_volume <= cmd_q.last;
		end
	end

endmodule

`default_nettype wire

>>> hdl/laplacian_stencil_3d.sv
// Seven-point 3D Laplacian, raster-order stream. A point's result reaches the result
// ports after the transaction that completes it, through queue, dispatch, seven
// window reads of the single window read port, multiply and output load. Samples of
// the first plane go in one per cycle while the command queue is empty; after that a
// sample waits until the back end took the queued point. Drains queue two deep.
// Reset (arst_n, async low): edge_in_use = 16, scale = 640000, all positions zero.
`default_nettype none

module laplacian_stencil_3d (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// APB-style configuration port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [lap3d_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [lap3d_pkg::PDATA_W-1:0]         pwdata,
	output logic      [lap3d_pkg::PDATA_W-1:0]         prdata,
	output logic                                       pready,
	// input queue side
	input  wire logic                                  push,
	output logic                                       full,
	input  wire logic                                  opcode,
	input  wire logic signed [lap3d_pkg::SAMPLE_W-1:0] sample,
	// result queue side
	output logic                                       empty,
	input  wire logic                                  pop,
	output logic signed [lap3d_pkg::RATE_W-1:0]        rate_value,
	output logic [lap3d_pkg::IDX_W-1:0]                point_index,
	output logic                                       last_of_volume
);
	import lap3d_pkg::*;

	localparam int EDGE_MIN = 2;
	localparam int E_RESET  = (EDGE_RESET > EDGE_MAX) ? EDGE_MAX : EDGE_RESET;

	// edge length is clamped once, at the write
	function automatic logic [EW-1:0] clamp_edge(input logic [EDGE_IN_W-1:0] v);
		if (int'(v) < EDGE_MIN) begin
			clamp_edge = EW'(EDGE_MIN);
		end else if (int'(v) > EDGE_MAX) begin
			clamp_edge = EW'(EDGE_MAX);
		end else begin
			clamp_edge = EW'(v);
		end
	endfunction

	// configuration registers, raw as written, and derived edge / plane size
	logic [EDGE_IN_W-1:0] edge_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [EW-1:0]        e_q;
	logic [PW-1:0]        plane_q;

	logic          cfg_wr;
	logic          restart;
	logic [EW-1:0] e_nxt;
	logic [PW-1:0] e_wide;
	logic [CW-1:0] em1;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign restart = cfg_wr && (paddr[2] == REG_EDGE);
	assign e_nxt   = clamp_edge(pwdata[EDGE_IN_W-1:0]);
	assign e_wide  = PW'(e_nxt);
	assign em1     = CW'(e_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q  <= EDGE_IN_W'(EDGE_RESET);
			scale_q <= SCALE_W'(SCALE_RESET);
			e_q     <= EW'(E_RESET);
			plane_q <= PW'(E_RESET * E_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_EDGE: begin
					edge_q  <= pwdata[EDGE_IN_W-1:0];
					e_q     <= e_nxt;
					plane_q <= e_wide * e_wide;
				end
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EDGE:  prdata = PDATA_W'(edge_q);
			REG_SCALE: prdata = PDATA_W'(scale_q);
			default:   prdata = '0;
		endcase
	end

	// front end: classify transactions, track positions, fill the window
	wr_t      wr;
	cq_stat_t cq_stat;
	cmd_t     cq_cmd, cq_head;
	logic     cq_push, cq_pop;

	lap3d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.opcode  (opcode),
		.sample  (sample),
		.em1     (em1),
		.restart (restart),
		.cq_stat (cq_stat),
		.full    (full),
		.wr      (wr),
		.cq_push (cq_push),
		.cq_cmd  (cq_cmd)
	);

	// point commands between front and back
	lap3d_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cq_push),
		.push_cmd (cq_cmd),
		.pop      (cq_pop),
		.stat     (cq_stat),
		.head     (cq_head)
	);

	// two planes plus one sample; contents undefined until written
	logic [AW-1:0]          raddr;
	logic [SAMPLE_BITS-1:0] rdata;

	lap3d_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WIN_SIZE)
	) u_window (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	// back end: gather the stencil, scale, hold the result until popped
	logic res_valid;

	lap3d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.e              (e_q),
		.plane          (plane_q),
		.scale          (scale_q),
		.cq_stat        (cq_stat),
		.cq_head        (cq_head),
		.cq_pop         (cq_pop),
		.raddr          (raddr),
		.rdata          (rdata),
		.pop            (pop),
		.res_valid      (res_valid),
		.rate_value     (rate_value),
		.point_index    (point_index),
		.last_of_volume (last_of_volume)
	);

	assign empty = !res_valid;

`ifndef SYNTHESIS
	// front never pushes into a full command queue
	a_cq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_push |-> !cq_stat.full)
		else $error("command queue overflow");

	// back never takes from an empty command queue
	a_cq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_stat.empty)
		else $error("command queue underflow");

	// a window write only happens with no point waiting for its oldest read
	a_window_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> cq_stat.empty)
		else $error("window write while a point is queued");

	// a result is loaded only after a command was taken
	a_result_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!cq_stat.empty, 10) || $past(cq_pop, 9))
		else $error("result without a command");
`endif

endmodule

`default_nettype wire

>>> tb/laplacian_stencil_3d_tb.sv
`default_nettype none

// Checks the seven-point 3D Laplacian stream block from its queue-style ports.
// A predictor inside this module holds its own copy of the plane window, the
// raster positions and both registers. Every accepted input transaction is
// run through it, and each result the block gives is matched against the
// oldest predicted one. Sender bursts and receiver stalls are random.
module laplacian_stencil_3d_tb;

	import lap3d_pkg::*;

	// stop sending random volumes once this many effective transactions went in
	localparam int RANDOM_ITEMS = 700;
	// settle time after the last result before a register write or the end:
	// covers the block's pipeline plus whatever sits in its input queue
	localparam int SETTLE_CYCLES = 64;
	localparam int TIMEOUT = 2_000_000;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
	localparam longint RATE_MAX = (longint'(1) <<< (RATE_W - 1)) - 1;
	localparam longint RATE_MIN = -(longint'(1) <<< (RATE_W - 1));

	typedef struct {
		logic signed [RATE_W-1:0] rate;
		logic [IDX_W-1:0]         idx;
		logic                     last;
	} point_rate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [PDATA_W-1:0]         pwdata;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;
	logic                       push;
	logic                       full;
	logic                       opcode;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       empty;
	logic                       pop = 1'b0;
	logic signed [RATE_W-1:0]   rate_value;
	logic [IDX_W-1:0]           point_index;
	logic                       last_of_volume;

	laplacian_stencil_3d u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.sample         (sample),
		.empty          (empty),
		.pop            (pop),
		.rate_value     (rate_value),
		.point_index    (point_index),
		.last_of_volume (last_of_volume)
	);

	initial forever #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: register copies and the streaming window
	// ------------------------------------------------------------------
	logic [EDGE_IN_W-1:0]          edge_reg;
	logic [SCALE_W-1:0]            scale_reg;
	logic signed [SAMPLE_BITS-1:0] win_mem [WIN_SIZE];
	int unsigned                   in_pos;
	int unsigned                   out_pos;
	int unsigned                   pend_cnt;

	point_rate_t expected_rates [$];

	int error_count;
	int samples_sent;
	int drains_sent;
	int effective_items;
	int reg_writes;
	int results_checked;
	int volumes_done;
	int burst_left;

	// receiver stall pattern
	int stall_mode;
	int mode_left;
	int phase;

	// register values outside [2, EDGE_MAX] act as the nearest bound
	function automatic int unsigned grid_edge();
		if (edge_reg < 2) return 2;
		if (edge_reg > EDGE_MAX) return EDGE_MAX;
		return int'(edge_reg);
	endfunction

	function automatic longint window_at(int unsigned pos);
		return longint'(win_mem[pos % WIN_SIZE]);
	endfunction

	// Finish the oldest pending point: in-grid face neighbours minus count
	// times centre, times scale, floor-shifted by 8 fractional bits.
	function automatic void finish_point();
		int unsigned e, plane, total, o, x, y, z;
		longint centre, sum, nbrs, prod, q;
		point_rate_t r;
		e = grid_edge();
		plane = e * e;
		total = plane * e;
		o = out_pos;
		x = o % e;
		y = (o / e) % e;
		z = o / plane;
		centre = window_at(o);
		sum = 0;
		nbrs = 0;
		if (z > 0) begin
			sum += window_at(o - plane);
			nbrs++;
		end
		if (y > 0) begin
			sum += window_at(o - e);
			nbrs++;
		end
		if (x > 0) begin
			sum += window_at(o - 1);
			nbrs++;
		end
		if (x + 1 < e) begin
			sum += window_at(o + 1);
			nbrs++;
		end
		if (y + 1 < e) begin
			sum += window_at(o + e);
			nbrs++;
		end
		if (z + 1 < e) begin
			sum += window_at(o + plane);
			nbrs++;
		end
		sum -= nbrs * centre;
		prod = sum * longint'(scale_reg);
		q = prod >>> 8;
		if (q > RATE_MAX) q = RATE_MAX;
		else if (q < RATE_MIN) q = RATE_MIN;
		r.rate = q[RATE_W-1:0];
		r.idx = o[IDX_W-1:0];
		r.last = (o + 1 >= total);
		expected_rates.push_back(r);
		if (r.last) begin
			// volume done, next sample opens a fresh one
			in_pos = 0;
			out_pos = 0;
			pend_cnt = 0;
		end else begin
			out_pos = o + 1;
			if (pend_cnt > 0) pend_cnt--;
		end
	endfunction

	// Returns 1 when the transaction had an effect (stored or flushed a point).
	function automatic bit stencil_step(logic op, logic signed [SAMPLE_W-1:0] value);
		int unsigned e, plane, total;
		e = grid_edge();
		plane = e * e;
		total = plane * e;
		if (op == OP_SAMPLE) begin
			// volume complete but not yet flushed: sample is dropped
			if (in_pos >= total) return 1'b0;
			win_mem[in_pos % WIN_SIZE] = value[SAMPLE_BITS-1:0];
			in_pos++;
			pend_cnt++;
			if (pend_cnt > plane) finish_point();
			return 1'b1;
		end
		// drain only counts once the whole volume is in
		if (in_pos >= total && pend_cnt > 0) begin
			finish_point();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps in between. push stays
	// high across a burst so back-to-back transactions are exercised.
	// ------------------------------------------------------------------
	task automatic send_item(logic op, logic signed [SAMPLE_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		opcode <= op;
		sample <= value;
		do @(posedge clk); while (full);
		if (op == OP_SAMPLE) samples_sent++;
		else drains_sent++;
		if (stencil_step(op, value)) effective_items++;
	endtask

	// Block is idle once every predicted result has been popped and the
	// pipeline has had time to retire trailing no-result transactions.
	task automatic wait_idle();
		push <= 1'b0;
		while (expected_rates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup then access; the register takes it on the access edge.
	task automatic apb_write(logic idx, logic [PDATA_W-1:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_EDGE) begin
			// edge write restarts the volume
			edge_reg = value[EDGE_IN_W-1:0];
			in_pos = 0;
			out_pos = 0;
			pend_cnt = 0;
		end else begin
			scale_reg = value[SCALE_W-1:0];
		end
		reg_writes++;
	endtask

	// extremes, small values around zero, and full-range noise
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SCALE_W-1:0] rand_scale();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SCALE_MAX;
			default: return $urandom;
		endcase
	endfunction

	// One complete volume plus its flush. With noise on, stray drains land
	// mid-volume, a surplus sample may follow the last one, and a drain may
	// arrive after the volume has wrapped; all of these must be ignored.
	task automatic send_volume(bit noisy);
		int unsigned e, total;
		e = grid_edge();
		total = e * e * e;
		for (int unsigned i = 0; i < total; i++) begin
			if (noisy && $urandom_range(0, 15) == 0) send_item(OP_DRAIN, $urandom);
			send_item(OP_SAMPLE, rand_sample());
		end
		if (noisy && $urandom_range(0, 3) == 0) send_item(OP_SAMPLE, rand_sample());
		for (int unsigned i = 0; i < e * e; i++) send_item(OP_DRAIN, $urandom);
		if (noisy && $urandom_range(0, 3) == 0) send_item(OP_DRAIN, $urandom);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: largest grid (16^3) at the default scale, full flush.
	task automatic test_reset_volume();
		send_volume(1'b0);
	endtask

	// Smallest grid, largest scale, checkerboard of extremes so every
	// corner point sees the biggest stencil magnitude. Also ignored drains
	// and samples, and floor rounding of small negative sums.
	task automatic test_directed_corners();
		apb_write(REG_EDGE, 32'd2);
		apb_write(REG_SCALE, PDATA_W'(SCALE_MAX));
		send_item(OP_DRAIN, '0);                  // too early: ignored
		send_item(OP_SAMPLE, SAMPLE_MAX);
		send_item(OP_SAMPLE, SAMPLE_MIN);
		send_item(OP_SAMPLE, SAMPLE_MIN);
		send_item(OP_SAMPLE, SAMPLE_MAX);
		send_item(OP_SAMPLE, SAMPLE_MIN);
		send_item(OP_SAMPLE, SAMPLE_MAX);
		send_item(OP_SAMPLE, SAMPLE_MAX);
		send_item(OP_SAMPLE, SAMPLE_MIN);
		send_item(OP_SAMPLE, '1);                 // volume full, pending: ignored
		repeat (4) send_item(OP_DRAIN, '1);
		send_item(OP_DRAIN, '1);                  // after wrap: ignored
		// scale of one LSB: results are tiny, negative ones round down
		apb_write(REG_SCALE, 32'd1);
		send_item(OP_SAMPLE, 32'sd0);
		send_item(OP_SAMPLE, 32'sd1);
		send_item(OP_SAMPLE, -32'sd1);
		send_item(OP_SAMPLE, 32'sd0);
		send_item(OP_SAMPLE, 32'sd300);
		send_item(OP_SAMPLE, 32'sd0);
		send_item(OP_SAMPLE, -32'sd2);
		send_item(OP_SAMPLE, 32'sd0);
		repeat (4) send_item(OP_DRAIN, '0);
	endtask

	// Edge register values outside the legal range clamp to the bounds.
	task automatic test_edge_clamp();
		apb_write(REG_EDGE, 32'd0);
		apb_write(REG_SCALE, 32'd0);
		send_volume(1'b1);
		apb_write(REG_EDGE, 32'd1);
		apb_write(REG_SCALE, PDATA_W'(rand_scale()));
		send_volume(1'b1);
		// 31 behaves as 16: a bit over one plane, so some points finish
		apb_write(REG_EDGE, 32'd31);
		repeat (300) send_item(OP_SAMPLE, rand_sample());
	endtask

	// Edge write mid-volume drops the partial volume; then two volumes in a
	// row with no write in between to cover the wrap to a new volume.
	task automatic test_restart();
		apb_write(REG_EDGE, 32'd4);
		apb_write(REG_SCALE, PDATA_W'(rand_scale()));
		repeat (40) send_item(OP_SAMPLE, rand_sample());
		apb_write(REG_EDGE, 32'd3);
		send_volume(1'b1);
		send_volume(1'b1);
	endtask

	// Random volumes: mostly small grids, well formed with some noise;
	// now and then a volume is cut short by the next edge write.
	task automatic test_random_volumes();
		int start;
		int unsigned e, sel;
		start = effective_items;
		while (effective_items - start < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			e = (sel < 6) ? $urandom_range(2, 3) : (sel < 9) ? $urandom_range(4, 5) : 6;
			apb_write(REG_EDGE, PDATA_W'(e));
			if ($urandom_range(0, 2) != 0) apb_write(REG_SCALE, PDATA_W'(rand_scale()));
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, e * e * e - 1)) send_item(OP_SAMPLE, rand_sample());
			end else begin
				send_volume(1'b1);
				if ($urandom_range(0, 2) == 0) send_volume(1'b1);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: pops on a stall pattern that switches between always
	// ready, coin flip, long stalls and a fixed duty cycle.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_rates.size() == 0) begin
					report_mismatch($sformatf("unexpected result index %0d", point_index));
				end else begin
					point_rate_t want;
					want = expected_rates.pop_front();
					if (rate_value !== want.rate)
						report_mismatch($sformatf("point %0d rate_value %0d, want %0d",
							want.idx, rate_value, want.rate));
					if (point_index !== want.idx)
						report_mismatch($sformatf("point_index %0d, want %0d",
							point_index, want.idx));
					if (last_of_volume !== want.last)
						report_mismatch($sformatf("point %0d last_of_volume %0b, want %0b",
							want.idx, last_of_volume, want.last));
					if (want.last) volumes_done++;
				end
				results_checked++;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			phase++;
			case (stall_mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				2: pop <= ($urandom_range(0, 7) == 0);
				default: pop <= (phase % 7 < 4);
			endcase
		end
	end

	initial begin
		#TIMEOUT;
		$display("timeout with %0d results outstanding", expected_rates.size());
		$display("FAIL laplacian_stencil_3d");
		$finish;
	end

	initial begin
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		push <= 1'b0;
		opcode <= OP_SAMPLE;
		sample <= '0;
		// predictor starts from the reset state
		edge_reg = EDGE_IN_W'(EDGE_RESET);
		scale_reg = SCALE_W'(SCALE_RESET);
		for (int i = 0; i < WIN_SIZE; i++) win_mem[i] = '0;
		in_pos = 0;
		out_pos = 0;
		pend_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_volume();
		test_directed_corners();
		test_edge_clamp();
		test_restart();
		test_random_volumes();
		wait_idle();

		$display("sent %0d samples and %0d drains over %0d register writes",
			samples_sent, drains_sent, reg_writes);
		$display("checked %0d results, %0d full volumes, %0d mismatches",
			results_checked, volumes_done, error_count);
		if (error_count == 0) begin
			$display("PASS laplacian_stencil_3d");
		end else begin
			$display("FAIL laplacian_stencil_3d");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
hdl/lap3d_pkg.sv
hdl/lap3d_ram.sv
hdl/lap3d_front.sv
hdl/lap3d_cmdq.sv
hdl/lap3d_back.sv
hdl/laplacian_stencil_3d.sv
tb/laplacian_stencil_3d_tb.sv
